// File: rtl/crbr_pkg.sv
// Shared types, constants and brake table for the conservative request brake ramp.
package crbr_pkg;

    localparam int unsigned KIND_W   = 3;
    localparam int unsigned SPEED_W  = 16;
    localparam int unsigned MARGIN_W = 12;
    localparam int unsigned LEVEL_W  = 13;
    localparam int unsigned DVD_W    = 30;
    localparam int unsigned DIV_BITS = 2;
    localparam int unsigned DIV_STEPS = DVD_W / DIV_BITS;
    localparam int unsigned CNT_W    = $clog2(DIV_STEPS);

    localparam logic [LEVEL_W-1:0]  FULL_BRAKE   = 13'd4096;
    localparam logic [SPEED_W-1:0]  CRUISE_RESET = 16'd12288;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 12'd82;

    // register index, taken from paddr[2]
    localparam logic REG_CRUISE = 1'b0;
    localparam logic REG_MARGIN = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ENDPOINT  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_EMERGENCY = 3'd1;
    localparam logic [KIND_W-1:0] KIND_HARD_STOP = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SOFT_STOP = 3'd3;
    localparam logic [KIND_W-1:0] KIND_HARD_SLOW = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SOFT_SLOW = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SPEED_W-1:0] target;
        logic [SPEED_W-1:0] vspeed;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_ADD,
        S_DIV,
        S_FIN,
        S_DONE
    } t_back_state;

    function automatic logic [LEVEL_W-1:0] kind_brake_min(input logic [KIND_W-1:0] kind);
        logic [LEVEL_W-1:0] v;
        case (kind)
            KIND_ENDPOINT:  v = 13'd1229;
            KIND_EMERGENCY: v = 13'd3277;
            KIND_HARD_STOP: v = 13'd1638;
            KIND_SOFT_STOP: v = 13'd1229;
            KIND_HARD_SLOW: v = 13'd1638;
            KIND_SOFT_SLOW: v = 13'd819;
            default:        v = 13'd0;
        endcase
        return v;
    endfunction

    function automatic logic [LEVEL_W-1:0] kind_brake_max(input logic [KIND_W-1:0] kind);
        logic [LEVEL_W-1:0] v;
        case (kind)
            KIND_ENDPOINT:  v = 13'd2458;
            KIND_EMERGENCY: v = 13'd4096;
            KIND_HARD_STOP: v = 13'd2458;
            KIND_SOFT_STOP: v = 13'd2458;
            KIND_HARD_SLOW: v = 13'd3277;
            KIND_SOFT_SLOW: v = 13'd2048;
            default:        v = 13'd0;
        endcase
        return v;
    endfunction

    // true when (k1, s1) is strictly more conservative than (k2, s2)
    function automatic logic more_conservative(
        input logic [KIND_W-1:0]  k1,
        input logic [SPEED_W-1:0] s1,
        input logic [KIND_W-1:0]  k2,
        input logic [SPEED_W-1:0] s2
    );
        logic [LEVEL_W:0] sum1;
        logic [LEVEL_W:0] sum2;
        logic             res;
        sum1 = {1'b0, kind_brake_min(k1)} + {1'b0, kind_brake_max(k1)};
        sum2 = {1'b0, kind_brake_min(k2)} + {1'b0, kind_brake_max(k2)};
        if (s1 != s2) begin
            res = (s1 < s2);
        end else if (sum1 != sum2) begin
            res = (sum1 > sum2);
        end else begin
            res = (kind_brake_min(k1) > kind_brake_min(k2));
        end
        return res;
    endfunction

endpackage

// File: rtl/crbr_if.sv
// Valid/ready channel interfaces for request items and result items.
interface crbr_in_if
    import crbr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  request_kind;
    logic [SPEED_W-1:0] request_speed;
    logic [SPEED_W-1:0] vehicle_speed;
    logic               round_end;

    modport source (
        output valid, request_kind, request_speed, vehicle_speed, round_end,
        input  ready
    );
    modport sink (
        input  valid, request_kind, request_speed, vehicle_speed, round_end,
        output ready
    );
endinterface

interface crbr_out_if
    import crbr_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  chosen_kind;
    logic [SPEED_W-1:0] chosen_speed;
    logic [LEVEL_W-1:0] brake_level;
    logic               brake_clipped;

    modport source (
        output valid, chosen_kind, chosen_speed, brake_level, brake_clipped,
        input  ready
    );
    modport sink (
        input  valid, chosen_kind, chosen_speed, brake_level, brake_clipped,
        output ready
    );
endinterface

// File: rtl/conservative_request_brake_ramp_core.sv
// Top level: config registers, request front end, job queue and brake unit.
// A non-final item is taken whenever the job queue has room; a round-ending item's result
// comes from the brake unit after its calculate, add, divide (two quotient bits per step)
// and finish states, or straight from calculate when the level is zero or the kind's maximum.
// The brake unit takes a new job only once the last result is loaded; the job queue lets
// the front end keep taking items meanwhile, until the queue is full.
// Reset (synchronous, active low) clears the held request, queue and result; cruise_speed
// returns to 12288 and speed_margin to 82.
module conservative_request_brake_ramp_core
    import crbr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    crbr_in_if.sink     i_in,
    crbr_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [SPEED_W-1:0]  r_cruise;
    logic [MARGIN_W-1:0] r_margin;

    logic cfg_wr;
    logic push_valid;
    t_job push_job;
    logic push_ready;
    logic pop_valid;
    t_job pop_job;
    logic pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cruise <= CRUISE_RESET;
            r_margin <= MARGIN_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_CRUISE: r_cruise <= pwdata[SPEED_W-1:0];
                REG_MARGIN: r_margin <= pwdata[MARGIN_W-1:0];
                default:    r_cruise <= r_cruise;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_CRUISE: prdata = {16'b0, r_cruise};
            REG_MARGIN: prdata = {20'b0, r_margin};
            default:    prdata = '0;
        endcase
    end

    crbr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push       (push_job),
        .i_push_ready (push_ready)
    );

    crbr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push       (push_job),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop        (pop_job),
        .i_pop        (pop)
    );

    crbr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (pop_valid),
        .i_job       (pop_job),
        .o_job_pop   (pop),
        .i_cruise    (r_cruise),
        .i_margin    (r_margin),
        .o_out       (o_out)
    );

endmodule

// File: rtl/crbr_front.sv
// Front end: accepts request items and keeps the most conservative one of the round.
module crbr_front
    import crbr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    crbr_in_if.sink    i_in,
    output logic       o_push_valid,
    output t_job       o_push,
    input  logic       i_push_ready
);

    logic               r_holding;
    logic [KIND_W-1:0]  r_held_kind;
    logic [SPEED_W-1:0] r_held_speed;

    logic               fire;
    logic               replace;
    logic [KIND_W-1:0]  sel_kind;
    logic [SPEED_W-1:0] sel_speed;

    assign i_in.ready = i_push_ready;
    assign fire       = i_in.valid && i_push_ready;

    always_comb begin
        replace = !r_holding || more_conservative(i_in.request_kind, i_in.request_speed,
                                                  r_held_kind, r_held_speed);
        sel_kind  = replace ? i_in.request_kind  : r_held_kind;
        sel_speed = replace ? i_in.request_speed : r_held_speed;
    end

    assign o_push_valid  = fire && i_in.round_end;
    assign o_push.kind   = sel_kind;
    assign o_push.target = sel_speed;
    assign o_push.vspeed = i_in.vehicle_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_holding    <= 1'b0;
            r_held_kind  <= '0;
            r_held_speed <= '0;
        end else if (fire) begin
            // drop the held request once the round closes
            if (i_in.round_end) begin
                r_holding    <= 1'b0;
                r_held_kind  <= '0;
                r_held_speed <= '0;
            end else begin
                r_holding    <= 1'b1;
                r_held_kind  <= sel_kind;
                r_held_speed <= sel_speed;
            end
        end
    end

endmodule

// File: rtl/crbr_queue.sv
// Short FIFO of round jobs between the front end and the brake unit.
module crbr_queue
    import crbr_pkg::*;
#(
    parameter int unsigned DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    input  t_job i_push,
    output logic o_push_ready,
    output logic o_pop_valid,
    output t_job o_pop,
    input  logic i_pop
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [AW:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_push_ready = (r_count != (AW+1)'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop        = r_mem[r_rptr];
    assign do_push      = i_push_valid && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: rtl/crbr_back.sv
// Back end: brake ramp with a two-bit-per-cycle restoring divider and result register.
module crbr_back
    import crbr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  t_job                i_job,
    output logic                o_job_pop,
    input  logic [SPEED_W-1:0]  i_cruise,
    input  logic [MARGIN_W-1:0] i_margin,
    crbr_out_if.source          o_out
);

    t_back_state r_state;
    t_back_state n_state;

    t_job               r_job;
    logic [DVD_W-1:0]   r_dvd;
    logic [SPEED_W-1:0] r_den;
    logic [SPEED_W-1:0] r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic [LEVEL_W-1:0] r_level;
    logic               r_clip;

    logic               r_out_valid;
    logic [KIND_W-1:0]  r_out_kind;
    logic [SPEED_W-1:0] r_out_speed;
    logic [LEVEL_W-1:0] r_out_level;
    logic               r_out_clip;

    logic               load_out;
    logic [SPEED_W:0]   thresh;
    logic               below;
    logic               flat;
    logic [LEVEL_W-1:0] lo;
    logic [LEVEL_W-1:0] hi;
    logic [SPEED_W-1:0] excess;
    logic [SPEED_W:0]   step_a;
    logic [SPEED_W:0]   step_b;
    logic               q_a;
    logic               q_b;
    logic [SPEED_W-1:0] rem_a;
    logic [SPEED_W-1:0] rem_b;
    logic [DVD_W:0]     fin_sum;
    logic               fin_clip;

    // ramp classification
    always_comb begin
        lo     = kind_brake_min(r_job.kind);
        hi     = kind_brake_max(r_job.kind);
        thresh = {1'b0, r_job.target} + {5'b0, i_margin};
        below  = ({1'b0, r_job.vspeed} < thresh);
        flat   = (i_cruise <= r_job.target);
        excess = r_job.vspeed - thresh[SPEED_W-1:0];
    end

    // two restoring division steps per cycle
    always_comb begin
        step_a = {r_rem, r_dvd[DVD_W-1]};
        q_a    = (step_a >= {1'b0, r_den});
        rem_a  = q_a ? SPEED_W'(step_a - {1'b0, r_den}) : step_a[SPEED_W-1:0];
        step_b = {rem_a, r_dvd[DVD_W-2]};
        q_b    = (step_b >= {1'b0, r_den});
        rem_b  = q_b ? SPEED_W'(step_b - {1'b0, r_den}) : step_b[SPEED_W-1:0];
    end

    always_comb begin
        fin_sum  = {(DVD_W+1-LEVEL_W)'(0), lo} + {1'b0, r_dvd};
        fin_clip = (fin_sum > {(DVD_W+1-LEVEL_W)'(0), FULL_BRAKE});
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_job_valid) n_state = S_CALC;
            S_CALC: n_state = (below || flat) ? S_DONE : S_ADD;
            S_ADD:  n_state = S_DIV;
            S_DIV:  if (r_cnt == '0) n_state = S_FIN;
            S_FIN:  n_state = S_DONE;
            S_DONE: if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_job_pop = 1'b0;
        load_out  = 1'b0;
        case (r_state)
            S_IDLE:  o_job_pop = i_job_valid;
            S_DONE:  load_out  = !r_out_valid || o_out.ready;
            default: begin
                o_job_pop = 1'b0;
                load_out  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_job <= i_job;
            end
            S_CALC: begin
                r_clip <= 1'b0;
                r_level <= below ? '0 : hi;
                r_dvd  <= {(DVD_W-LEVEL_W)'(0), hi - lo} * {(DVD_W-SPEED_W)'(0), excess};
                r_den  <= i_cruise - r_job.target;
            end
            S_ADD: begin
                // round to nearest, halves up
                r_dvd <= r_dvd + {(DVD_W-SPEED_W+1)'(0), r_den[SPEED_W-1:1]};
                r_rem <= '0;
                r_cnt <= CNT_W'(DIV_STEPS - 1);
            end
            S_DIV: begin
                r_dvd <= {r_dvd[DVD_W-3:0], q_a, q_b};
                r_rem <= rem_b;
                r_cnt <= r_cnt - 1'b1;
            end
            S_FIN: begin
                r_clip  <= fin_clip;
                r_level <= fin_clip ? FULL_BRAKE : fin_sum[LEVEL_W-1:0];
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_kind  <= r_job.kind;
            r_out_speed <= r_job.target;
            r_out_level <= r_level;
            r_out_clip  <= r_clip;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.chosen_kind   = r_out_kind;
    assign o_out.chosen_speed  = r_out_speed;
    assign o_out.brake_level   = r_out_level;
    assign o_out.brake_clipped = r_out_clip;

`ifndef SYNTHESIS
    a_clip_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_clip) |-> (r_out_level == FULL_BRAKE))
        else $error("clipped result not at full brake");

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_level <= FULL_BRAKE))
        else $error("brake level above full brake");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_FIN))
        else $error("divider did not finish");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> (r_state == S_CALC))
        else $error("job pop did not start a calculation");
`endif

endmodule
